@@ src/vaxr_pkg.sv @@
package vaxr_pkg;

	// Fixed field widths
	localparam int VOXEL_W    = 8;
	localparam int ADDR_W     = 30;
	localparam int CODE_W     = 3;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 11;
	localparam int AXES       = 3;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DIM_X       = 3'd0,
		REG_DIM_Y       = 3'd1,
		REG_DIM_Z       = 3'd2,
		REG_AXIS_CODE_X = 3'd3,
		REG_AXIS_CODE_Y = 3'd4,
		REG_AXIS_CODE_Z = 3'd5
	} cfg_reg_t;

	// Reset values of the axis codes: identity orientation
	localparam logic [CODE_W-1:0] CODE_RESET_X = 3'd1;
	localparam logic [CODE_W-1:0] CODE_RESET_Y = 3'd2;
	localparam logic [CODE_W-1:0] CODE_RESET_Z = 3'd3;

	// Decoded orientation: source axis and flip for each destination axis
	typedef struct packed {
		logic [AXES-1:0][1:0] src;
		logic [AXES-1:0]      flip;
		logic                 err;
	} axis_map_t;

	// Decode three signed axis codes, flag anything that is not a permutation
	function automatic axis_map_t decode_axes(input logic [AXES-1:0][CODE_W-1:0] codes);
		axis_map_t        m;
		logic [CODE_W-1:0] mag;
		logic [AXES-1:0]   bad;
		logic [AXES-1:0][1:0] hits;
		m    = '0;
		bad  = '0;
		hits = '0;
		for (int i = 0; i < AXES; i++) begin
			m.flip[i] = codes[i][CODE_W-1];
			mag = codes[i][CODE_W-1] ? CODE_W'(~codes[i] + CODE_W'(1)) : codes[i];
			if (mag >= CODE_W'(1) && mag <= CODE_W'(AXES)) begin
				m.src[i] = 2'(mag - CODE_W'(1));
				hits[m.src[i]] = hits[m.src[i]] + 2'd1;
			end else begin
				m.src[i] = 2'd0;
				bad[i]   = 1'b1;
			end
		end
		m.err = |bad;
		for (int i = 0; i < AXES; i++) begin
			if (hits[i] != 2'd1) begin
				m.err = 1'b1;
			end
		end
		return m;
	endfunction

endpackage

@@ src/vaxr_voxel_if.sv @@
interface vaxr_voxel_if import vaxr_pkg::*;;
	logic               valid;
	logic               ready;
	logic [VOXEL_W-1:0] voxel_in;

	modport source (output valid, output voxel_in, input ready);
	modport sink (input valid, input voxel_in, output ready);
endinterface

@@ src/vaxr_result_if.sv @@
interface vaxr_result_if import vaxr_pkg::*;;
	logic               valid;
	logic               ready;
	logic [VOXEL_W-1:0] voxel_out;
	logic [ADDR_W-1:0]  dest_address;
	logic               axis_error;
	logic               volume_last;

	modport source (output valid, output voxel_out, output dest_address,
		output axis_error, output volume_last, input ready);
	modport sink (input valid, input voxel_out, input dest_address,
		input axis_error, input volume_last, output ready);
endinterface

@@ src/vaxr_cfg_if.sv @@
interface vaxr_cfg_if import vaxr_pkg::*;;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  reg_index;
	logic [CFG_DATA_W-1:0] wdata;

	modport source (output valid, output reg_index, output wdata, input ready);
	modport sink (input valid, input reg_index, input wdata, output ready);
endinterface

@@ src/vaxr_raster_counter.sv @@
module vaxr_raster_counter import vaxr_pkg::*; #(
	parameter int MAX_DIM = 1024,
	localparam int DW = $clog2(MAX_DIM + 1),
	localparam int PW = $clog2(MAX_DIM)
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     advance,
	input  logic                     clear,
	input  logic [AXES-1:0][DW-1:0]  dims,
	output logic [AXES-1:0][PW-1:0]  pos,
	output logic                     last
);

	logic [AXES-1:0][PW-1:0] pos_q;
	logic [AXES-1:0]         at_end;

	// Detect the final coordinate on each axis
	always_comb begin
		for (int i = 0; i < AXES; i++) begin
			at_end[i] = !((DW'(pos_q[i]) + DW'(1)) < dims[i]);
		end
	end

	assign pos  = pos_q;
	assign last = &at_end;

	// Advance in raster order, x fastest; wrap after the final voxel
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (clear) begin
			pos_q <= '0;
		end else if (advance) begin
			if (!at_end[0]) begin
				pos_q[0] <= pos_q[0] + PW'(1);
			end else begin
				pos_q[0] <= '0;
				if (!at_end[1]) begin
					pos_q[1] <= pos_q[1] + PW'(1);
				end else begin
					pos_q[1] <= '0;
					if (!at_end[2]) begin
						pos_q[2] <= pos_q[2] + PW'(1);
					end else begin
						pos_q[2] <= '0;
					end
				end
			end
		end
	end

endmodule

@@ src/vaxr_addr_pipe.sv @@
module vaxr_addr_pipe import vaxr_pkg::*; #(
	parameter int MAX_DIM = 1024,
	localparam int DW  = $clog2(MAX_DIM + 1),
	localparam int PW  = $clog2(MAX_DIM),
	localparam int PLW = 2 * DW,
	localparam int RTW = PW + DW + 1,
	localparam int SW  = PW + 2 * DW + 1
) (
	input  logic                    clk,
	input  logic                    arst_n,
	vaxr_voxel_if.sink              voxels,
	vaxr_result_if.source           results,
	input  logic [AXES-1:0][PW-1:0] pos,
	input  logic                    last,
	input  logic [AXES-1:0][DW-1:0] dims,
	input  axis_map_t               amap
);

	// Stage valids and advance enables
	logic v_s1, v_s2, v_s3, v_s4;
	logic en_s1, en_s2, en_s3, en_s4;

	// Stage 1: captured word and source coordinate
	logic [VOXEL_W-1:0]      voxel_s1;
	logic [AXES-1:0][PW-1:0] pos_s1;
	logic                    last_s1;

	// Stage 2: destination coordinate and extents
	logic [VOXEL_W-1:0]      voxel_s2;
	logic [AXES-1:0][PW-1:0] tpos_s2;
	logic [AXES-1:0][DW-1:0] tdim_s2;
	logic                    last_s2;
	logic                    err_s2;

	// Stage 3: plane size and row term
	logic [VOXEL_W-1:0] voxel_s3;
	logic [PW-1:0]      zpos_s3;
	logic [PLW-1:0]     plane_s3;
	logic [RTW-1:0]     row_s3;
	logic               last_s3;
	logic               err_s3;

	// Stage 4: result register
	logic [VOXEL_W-1:0] voxel_s4;
	logic [ADDR_W-1:0]  addr_s4;
	logic               last_s4;
	logic               err_s4;

	logic [AXES-1:0][PW-1:0] tpos_n;
	logic [AXES-1:0][DW-1:0] tdim_n;
	logic [RTW-1:0]          row_n;
	logic [SW-1:0]           sum_n;

	// Advance a stage when it is empty or its successor advances
	assign en_s4 = !v_s4 || results.ready;
	assign en_s3 = !v_s3 || en_s4;
	assign en_s2 = !v_s2 || en_s3;
	assign en_s1 = !v_s1 || en_s2;
	assign voxels.ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= voxels.valid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
			if (en_s4) v_s4 <= v_s3;
		end
	end

	// Permute and flip the source coordinate
	always_comb begin
		for (int i = 0; i < AXES; i++) begin
			tdim_n[i] = dims[amap.src[i]];
			if (amap.flip[i]) begin
				tpos_n[i] = PW'(tdim_n[i] - DW'(1) - DW'(pos_s1[amap.src[i]]));
			end else begin
				tpos_n[i] = pos_s1[amap.src[i]];
			end
		end
	end

	assign row_n = RTW'(tpos_s2[1]) * RTW'(tdim_s2[0]) + RTW'(tpos_s2[0]);
	assign sum_n = SW'(zpos_s3) * SW'(plane_s3) + SW'(row_s3);

	// Hold payload while stalled
	always_ff @(posedge clk) begin
		if (en_s1) begin
			voxel_s1 <= voxels.voxel_in;
			pos_s1   <= pos;
			last_s1  <= last;
		end
		if (en_s2) begin
			voxel_s2 <= voxel_s1;
			tpos_s2  <= tpos_n;
			tdim_s2  <= tdim_n;
			last_s2  <= last_s1;
			err_s2   <= amap.err;
		end
		if (en_s3) begin
			voxel_s3 <= voxel_s2;
			zpos_s3  <= tpos_s2[2];
			plane_s3 <= PLW'(tdim_s2[1]) * PLW'(tdim_s2[0]);
			row_s3   <= row_n;
			last_s3  <= last_s2;
			err_s3   <= err_s2;
		end
		if (en_s4) begin
			voxel_s4 <= voxel_s3;
			addr_s4  <= err_s3 ? '0 : ADDR_W'(sum_n);
			last_s4  <= last_s3;
			err_s4   <= err_s3;
		end
	end

	assign results.valid        = v_s4;
	assign results.voxel_out    = voxel_s4;
	assign results.dest_address = addr_s4;
	assign results.axis_error   = err_s4;
	assign results.volume_last  = last_s4;

endmodule

@@ src/volume_axis_reorder_address_unit.sv @@
// Voxel reorder address unit: while ready, takes one voxel word per cycle in
// raster order (x fastest, then y, then z) and returns one result word per
// voxel with the value, its linear address in the volume reoriented by the
// three axis codes, an axis error flag and an end-of-volume mark. Sustained
// rate is one voxel per cycle while result words are taken. Each voxel passes
// through the four registers of the address path: input capture, axis permute,
// plane and row products, and depth product and sum into the result register.
// Input ready falls only when every stage holds a word and the result is not
// taken. Writing an extent resets the raster position to the origin; program
// registers only while idle.
module volume_axis_reorder_address_unit import vaxr_pkg::*; #(
	parameter int MAX_DIM = 1024
) (
	input  logic          clk,
	input  logic          arst_n,
	vaxr_cfg_if.sink      cfg,
	vaxr_voxel_if.sink    voxels,
	vaxr_result_if.source results
);

	localparam int DW = $clog2(MAX_DIM + 1);
	localparam int PW = $clog2(MAX_DIM);

	logic [AXES-1:0][DW-1:0]     dim_q;
	logic [AXES-1:0][CODE_W-1:0] code_q;
	logic [DW-1:0]               dim_wr;
	logic                        cfg_wr;
	logic                        dim_wr_en;
	axis_map_t                   amap;
	logic [AXES-1:0][PW-1:0]     pos;
	logic                        last;

	assign cfg.ready = 1'b1;
	assign cfg_wr    = cfg.valid && cfg.ready;

	// Clamp a written extent to the supported range
	always_comb begin
		if (cfg.wdata == '0) begin
			dim_wr = DW'(1);
		end else if (32'(cfg.wdata) > MAX_DIM) begin
			dim_wr = DW'(MAX_DIM);
		end else begin
			dim_wr = DW'(cfg.wdata);
		end
	end

	always_comb begin
		dim_wr_en = 1'b0;
		if (cfg_wr) begin
			case (cfg_reg_t'(cfg.reg_index))
				REG_DIM_X, REG_DIM_Y, REG_DIM_Z: dim_wr_en = 1'b1;
				default:                         dim_wr_en = 1'b0;
			endcase
		end
	end

	// Register file: clamped extents and axis codes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dim_q     <= {AXES{DW'(1)}};
			code_q[0] <= CODE_RESET_X;
			code_q[1] <= CODE_RESET_Y;
			code_q[2] <= CODE_RESET_Z;
		end else if (cfg_wr) begin
			case (cfg_reg_t'(cfg.reg_index))
				REG_DIM_X:       dim_q[0]  <= dim_wr;
				REG_DIM_Y:       dim_q[1]  <= dim_wr;
				REG_DIM_Z:       dim_q[2]  <= dim_wr;
				REG_AXIS_CODE_X: code_q[0] <= cfg.wdata[CODE_W-1:0];
				REG_AXIS_CODE_Y: code_q[1] <= cfg.wdata[CODE_W-1:0];
				REG_AXIS_CODE_Z: code_q[2] <= cfg.wdata[CODE_W-1:0];
				default:         ;
			endcase
		end
	end

	assign amap = decode_axes(code_q);

	vaxr_raster_counter #(
		.MAX_DIM (MAX_DIM)
	) u_counter (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (voxels.valid && voxels.ready),
		.clear   (dim_wr_en),
		.dims    (dim_q),
		.pos     (pos),
		.last    (last)
	);

	vaxr_addr_pipe #(
		.MAX_DIM (MAX_DIM)
	) u_pipe (
		.clk     (clk),
		.arst_n  (arst_n),
		.voxels  (voxels),
		.results (results),
		.pos     (pos),
		.last    (last),
		.dims    (dim_q),
		.amap    (amap)
	);

endmodule

@@ test/vaxr_checker.sv @@
module vaxr_checker import vaxr_pkg::*; #(
	parameter int MAX_DIM = 1024
) (
	input  logic   clk,
	input  logic   arst_n,
	vaxr_cfg_if    cfg,
	vaxr_voxel_if  voxels,
	vaxr_result_if results,
	output int     mismatches,
	output int     pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [VOXEL_W-1:0] voxel;
		logic [ADDR_W-1:0]  addr;
		logic               err;
		logic               last;
	} placement_t;

	// Shadow of the programmed registers and the raster position
	logic [CFG_DATA_W-1:0]    extent_reg [AXES];
	logic signed [CODE_W-1:0] code_reg [AXES];
	int unsigned              raster_pos [AXES];
	placement_t               placements [$];

	function automatic int unsigned clamp_extent(input logic [CFG_DATA_W-1:0] e);
		if (e == '0) begin
			return 1;
		end
		if (e > MAX_DIM) begin
			return MAX_DIM;
		end
		return e;
	endfunction

	// Work out where the voxel at the current raster position lands
	function automatic placement_t place_voxel(input logic [VOXEL_W-1:0] v);
		placement_t        p;
		int unsigned       ext [AXES];
		int unsigned       dext [AXES];
		int unsigned       dpos [AXES];
		int unsigned       src [AXES];
		int unsigned       hits [AXES];
		int                mag;
		longint unsigned   lin;
		p.voxel = v;
		p.addr  = '0;
		p.err   = 1'b0;
		p.last  = 1'b1;
		for (int i = 0; i < AXES; i++) begin
			ext[i]  = clamp_extent(extent_reg[i]);
			hits[i] = 0;
		end
		// Decode the axis codes; anything but a permutation is an error
		for (int i = 0; i < AXES; i++) begin
			mag = int'(code_reg[i]);
			if (mag < 0) begin
				mag = -mag;
			end
			if (mag < 1 || mag > AXES) begin
				p.err  = 1'b1;
				src[i] = 0;
			end else begin
				src[i] = mag - 1;
				hits[src[i]]++;
			end
		end
		for (int i = 0; i < AXES; i++) begin
			if (hits[i] != 1) begin
				p.err = 1'b1;
			end
		end
		if (!p.err) begin
			for (int i = 0; i < AXES; i++) begin
				dext[i] = ext[src[i]];
				dpos[i] = (code_reg[i] > 0) ? raster_pos[src[i]]
					: dext[i] - 1 - raster_pos[src[i]];
			end
			lin = 64'(dpos[2]) * dext[1] * dext[0] + 64'(dpos[1]) * dext[0] + dpos[0];
			p.addr = lin[ADDR_W-1:0];
		end
		for (int i = 0; i < AXES; i++) begin
			if (raster_pos[i] != ext[i] - 1) begin
				p.last = 1'b0;
			end
		end
		return p;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		placement_t  got;
		placement_t  want;
		int unsigned ext [AXES];
		if (!arst_n) begin
			extent_reg = '{default: CFG_DATA_W'(1)};
			code_reg   = '{CODE_RESET_X, CODE_RESET_Y, CODE_RESET_Z};
			raster_pos = '{0, 0, 0};
			placements.delete();
			mismatches = 0;
		end else begin
			// Apply a register write; an extent write returns to the origin
			if (cfg.valid && cfg.ready) begin
				case (cfg.reg_index)
					REG_DIM_X: begin
						extent_reg[0] = cfg.wdata;
						raster_pos    = '{0, 0, 0};
					end
					REG_DIM_Y: begin
						extent_reg[1] = cfg.wdata;
						raster_pos    = '{0, 0, 0};
					end
					REG_DIM_Z: begin
						extent_reg[2] = cfg.wdata;
						raster_pos    = '{0, 0, 0};
					end
					REG_AXIS_CODE_X: code_reg[0] = cfg.wdata[CODE_W-1:0];
					REG_AXIS_CODE_Y: code_reg[1] = cfg.wdata[CODE_W-1:0];
					REG_AXIS_CODE_Z: code_reg[2] = cfg.wdata[CODE_W-1:0];
					default: ;
				endcase
			end

			// Predict the accepted voxel word, then advance the raster
			if (voxels.valid && voxels.ready) begin
				placements.push_back(place_voxel(voxels.voxel_in));
				for (int i = 0; i < AXES; i++) begin
					ext[i] = clamp_extent(extent_reg[i]);
				end
				if (raster_pos[0] + 1 < ext[0]) begin
					raster_pos[0]++;
				end else begin
					raster_pos[0] = 0;
					if (raster_pos[1] + 1 < ext[1]) begin
						raster_pos[1]++;
					end else begin
						raster_pos[1] = 0;
						if (raster_pos[2] + 1 < ext[2]) begin
							raster_pos[2]++;
						end else begin
							raster_pos[2] = 0;
						end
					end
				end
			end

			// Compare the taken result word with the oldest prediction
			if (results.valid && results.ready) begin
				got = '{results.voxel_out, results.dest_address,
					results.axis_error, results.volume_last};
				if (placements.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("%0t: unexpected result word: voxel %0h addr %0d err %0b last %0b",
							$realtime, got.voxel, got.addr, got.err, got.last);
					end
				end else begin
					want = placements.pop_front();
					if (got !== want) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("%0t: mismatch: expected voxel %0h addr %0d err %0b last %0b",
								$realtime, want.voxel, want.addr, want.err, want.last);
							$display("%0t:           actual voxel %0h addr %0d err %0b last %0b",
								$realtime, got.voxel, got.addr, got.err, got.last);
						end
					end
				end
			end
		end
		pending = placements.size();
	end

endmodule

@@ test/tb_top.sv @@
module tb_top;
	import vaxr_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_DIM       = 1024;
	localparam int RANDOM_VOXELS = 1100;
	localparam int CYCLE_LIMIT   = 400000;

	// Indexes with no register behind them; writes there must change nothing
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

	logic clk;
	logic arst_n;
	int   mismatches;
	int   pending;
	int   cycles;
	int   sent;
	int   idle_pct;
	int   stall_pct;

	vaxr_cfg_if    cfg_bus();
	vaxr_voxel_if  voxel_bus();
	vaxr_result_if result_bus();

	volume_axis_reorder_address_unit #(.MAX_DIM(MAX_DIM)) uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_bus),
		.voxels  (voxel_bus),
		.results (result_bus)
	);

	vaxr_checker #(.MAX_DIM(MAX_DIM)) placement_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_bus),
		.voxels     (voxel_bus),
		.results    (result_bus),
		.mismatches (mismatches),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Stall the result side at random
	initial begin
		result_bus.ready = 1'b0;
		forever begin
			@(negedge clk);
			result_bus.ready = ($urandom_range(0, 99) >= stall_pct);
		end
	end

	// Stop a hung run
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// Axis code word with random bits above the code
	function automatic logic [CFG_DATA_W-1:0] axis_word(input int c);
		return {(CFG_DATA_W-CODE_W)'($urandom), c[CODE_W-1:0]};
	endfunction

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_bus.valid     = 1'b1;
		cfg_bus.reg_index = idx;
		cfg_bus.wdata     = data;
		do @(posedge clk); while (!cfg_bus.ready);
		@(negedge clk);
		cfg_bus.valid = 1'b0;
	endtask

	// Offer one voxel word after a random idle gap and hold it until taken
	task automatic send_voxel(input logic [VOXEL_W-1:0] v);
		while ($urandom_range(0, 99) < idle_pct) begin
			@(negedge clk);
			voxel_bus.valid    = 1'b0;
			voxel_bus.voxel_in = VOXEL_W'($urandom);
		end
		@(negedge clk);
		voxel_bus.valid    = 1'b1;
		voxel_bus.voxel_in = v;
		do @(posedge clk); while (!voxel_bus.ready);
		sent++;
	endtask

	// Drop valid and hold until every predicted word has come back
	task automatic quiesce();
		@(negedge clk);
		voxel_bus.valid = 1'b0;
		wait (pending == 0);
	endtask

	task automatic write_codes(input int cx, input int cy, input int cz);
		write_reg(REG_AXIS_CODE_X, axis_word(cx));
		write_reg(REG_AXIS_CODE_Y, axis_word(cy));
		write_reg(REG_AXIS_CODE_Z, axis_word(cz));
	endtask

	// Pick a new orientation, and new extents about half the time
	task automatic pick_orientation();
		logic [CFG_DATA_W-1:0] extremes [7];
		logic [CFG_DATA_W-1:0] ext [AXES];
		int                    perm [AXES];
		int                    r;
		int                    j;
		int                    t;
		extremes = '{11'd0, 11'd1, 11'd2, 11'd1023, 11'd1024, 11'd1025, 11'd2047};
		if ($urandom_range(0, 1) == 1) begin
			r = $urandom_range(0, 99);
			for (int i = 0; i < AXES; i++) begin
				if (r < 70) begin
					ext[i] = CFG_DATA_W'($urandom_range(1, 5));
				end else if (r < 85) begin
					ext[i] = CFG_DATA_W'($urandom_range(1, 3));
				end else begin
					ext[i] = extremes[$urandom_range(0, 6)];
				end
			end
			// Stretch one axis to a long random extent
			if (r >= 70 && r < 85) begin
				ext[$urandom_range(0, AXES-1)] = CFG_DATA_W'($urandom_range(1, MAX_DIM));
			end
			write_reg(REG_DIM_X, ext[0]);
			write_reg(REG_DIM_Y, ext[1]);
			write_reg(REG_DIM_Z, ext[2]);
		end
		if ($urandom_range(0, 3) != 0) begin
			// Valid permutation with random flips
			perm = '{1, 2, 3};
			for (int i = AXES - 1; i > 0; i--) begin
				j       = $urandom_range(0, i);
				t       = perm[i];
				perm[i] = perm[j];
				perm[j] = t;
			end
			for (int i = 0; i < AXES; i++) begin
				if ($urandom_range(0, 1) == 1) begin
					perm[i] = -perm[i];
				end
			end
			write_codes(perm[0], perm[1], perm[2]);
		end else begin
			write_codes($urandom_range(0, 7), $urandom_range(0, 7), $urandom_range(0, 7));
		end
	endtask

	initial begin : stimulus
		int n;
		int hold_at;
		int setting;
		int random_start;
		arst_n              = 1'b0;
		cfg_bus.valid       = 1'b0;
		cfg_bus.reg_index   = REG_DIM_X;
		cfg_bus.wdata       = '0;
		voxel_bus.valid     = 1'b0;
		voxel_bus.voxel_in  = '0;
		idle_pct            = 0;
		stall_pct           = 0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset orientation on a one-voxel volume: every word is the last
		send_voxel(8'h00);
		send_voxel(8'hFF);
		send_voxel(8'h55);
		send_voxel(8'hAA);
		quiesce();

		// Small volume, permuted and flipped; run past the end to see the wrap
		write_reg(REG_DIM_X, 11'd3);
		write_reg(REG_DIM_Y, 11'd2);
		write_reg(REG_DIM_Z, 11'd2);
		write_codes(-1, 3, -2);
		repeat (14) send_voxel(VOXEL_W'($urandom));
		quiesce();

		// Code writes keep the raster position; duplicate axis first, then a swap
		write_reg(REG_AXIS_CODE_X, axis_word(2));
		write_reg(REG_AXIS_CODE_Y, axis_word(1));
		send_voxel(VOXEL_W'($urandom));
		quiesce();
		write_reg(REG_AXIS_CODE_Z, axis_word(3));
		send_voxel(VOXEL_W'($urandom));
		quiesce();

		// Zero code and the most negative code both flag an error
		write_reg(REG_AXIS_CODE_X, axis_word(0));
		send_voxel(VOXEL_W'($urandom));
		quiesce();
		write_reg(REG_AXIS_CODE_X, axis_word(-4));
		send_voxel(VOXEL_W'($urandom));
		quiesce();

		// Extents past the top clamp, zero counts as one; spare indexes do nothing
		write_reg(REG_DIM_X, 11'd2047);
		write_reg(REG_DIM_Y, 11'd0);
		write_reg(REG_DIM_Z, 11'd1024);
		write_codes(-3, -1, -2);
		write_reg(REG_SPARE_6, CFG_DATA_W'($urandom));
		write_reg(REG_SPARE_7, CFG_DATA_W'($urandom));
		repeat (3) send_voxel(VOXEL_W'($urandom));
		quiesce();

		// Random settings, cycling through the idle and stall mixes
		setting      = 0;
		random_start = sent;
		while (sent - random_start < RANDOM_VOXELS) begin
			case (setting % 4)
				0: begin
					idle_pct  = 0;
					stall_pct = 0;
				end
				1: begin
					idle_pct  = 49;
					stall_pct = 0;
				end
				2: begin
					idle_pct  = 0;
					stall_pct = 49;
				end
				default: begin
					idle_pct  = 24;
					stall_pct = 24;
				end
			endcase
			pick_orientation();
			n       = $urandom_range(25, 80);
			hold_at = $urandom_range(1, n - 1);
			for (int i = 0; i < n; i++) begin
				if (i == hold_at) begin
					quiesce();
				end
				send_voxel(VOXEL_W'($urandom));
			end
			quiesce();
			setting++;
		end

		// Let any stray word show up before the verdict
		repeat (12) @(posedge clk);
		if (mismatches == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
